// ----- rtl/tvb_pkg.sv -----
// Shared constants for the transform vector blend core.
package tvb_pkg;

    localparam int WEIGHT_BITS = 16;
    localparam logic [WEIGHT_BITS:0] WEIGHT_ONE = 17'h10000;
    localparam int WEIGHT_HALF = 32768;

    localparam logic KIND_LINEAR   = 1'b0;
    localparam logic KIND_ROTATION = 1'b1;

    localparam int NORM_TOP  = 29;
    localparam int NORM_BITS = 30;
    localparam int SQ_BITS   = 62;
    localparam int ROOT_BITS = 31;
    localparam logic [63:0] DEG_DIVISOR = 64'd1000000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;

endpackage

// ----- rtl/tvb_front.sv -----
// Front pipeline: dot product sign, shortest path flip and weighted blend.
module tvb_front import tvb_pkg::*; #(
    parameter int CW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [WEIGHT_BITS:0] weight,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic signed [CW-1:0] s_src [4],
    input  logic signed [CW-1:0] s_tgt [4],
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic                 q_kind,
    output logic signed [CW+2:0] q_mix [4]
);

    logic [3:0] v_reg;
    logic       en;

    logic                   kind1_reg;
    logic signed [CW-1:0]   src1_reg [4];
    logic signed [CW-1:0]   tgt1_reg [4];
    logic signed [2*CW-1:0] prod1_reg [4];

    logic                 kind2_reg;
    logic                 neg2_reg;
    logic signed [CW-1:0] src2_reg [4];
    logic signed [CW-1:0] tgt2_reg [4];
    logic signed [2*CW+1:0] dot;

    logic                  kind3_reg;
    logic signed [CW+17:0] ps3_reg [4];
    logic signed [CW+18:0] pt3_reg [4];
    logic signed [CW:0]    tgt_eff [4];
    logic [WEIGHT_BITS:0]  wa;

    logic                  kind4_reg;
    logic signed [CW+2:0]  mix4_reg [4];
    logic signed [CW+19:0] acc [4];

    assign en = !v_reg[3] || q_ready;
    assign s_ready = en;
    assign q_valid = v_reg[3];
    assign q_kind = kind4_reg;
    assign q_mix = mix4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], s_valid};
        end
    end

    always_comb begin
        dot = '0;
        for (int i = 0; i < 4; i++) begin
            dot = dot + (2*CW+2)'(prod1_reg[i]);
        end
        wa = WEIGHT_ONE - weight;
        for (int i = 0; i < 4; i++) begin
            tgt_eff[i] = neg2_reg ? -((CW+1)'(tgt2_reg[i])) : (CW+1)'(tgt2_reg[i]);
            acc[i] = (CW+20)'(ps3_reg[i]) + (CW+20)'(pt3_reg[i]) + (CW+20)'(WEIGHT_HALF);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind1_reg <= s_kind;
            kind2_reg <= kind1_reg;
            neg2_reg  <= (kind1_reg == KIND_ROTATION) && dot[2*CW+1];
            kind3_reg <= kind2_reg;
            kind4_reg <= kind3_reg;
            for (int i = 0; i < 4; i++) begin
                src1_reg[i]  <= s_src[i];
                tgt1_reg[i]  <= s_tgt[i];
                prod1_reg[i] <= s_src[i] * s_tgt[i];
                src2_reg[i]  <= src1_reg[i];
                tgt2_reg[i]  <= tgt1_reg[i];
                ps3_reg[i]   <= src2_reg[i] * $signed({1'b0, wa});
                pt3_reg[i]   <= tgt_eff[i] * $signed({1'b0, weight});
                mix4_reg[i]  <= acc[i][CW+18:16];
            end
        end
    end

endmodule

// ----- rtl/tvb_queue.sv -----
// Short queue of blended words between the front and back pipelines.
module tvb_queue import tvb_pkg::*; #(
    parameter int CW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    input  logic signed [CW+2:0] in_mix [4],
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_kind,
    output logic signed [CW+2:0] out_mix [4]
);

    logic                 slot_kind_reg [QUEUE_DEPTH];
    logic signed [CW+2:0] slot_mix_reg [QUEUE_DEPTH][4];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic push, pop;

    assign in_ready  = count_reg != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_kind = slot_kind_reg[rd_ptr_reg];
    assign out_mix  = slot_mix_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_kind_reg[wr_ptr_reg] <= in_kind;
            slot_mix_reg[wr_ptr_reg]  <= in_mix;
        end
    end

endmodule

// ----- rtl/tvb_back.sv -----
// Back pipeline: degenerate test, normalization, square root, division and saturation.
module tvb_back import tvb_pkg::*; #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic                 q_kind,
    input  logic signed [CW+2:0] q_mix [4],
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [CW-1:0] m_out [4],
    output logic                 m_fallback
);

    localparam int MW = CW + 3;
    localparam int PW = $clog2(MW);
    localparam int SB = (FB > 10) ? FB - 9 : 1;
    localparam logic [63:0] THRESH = (64'd1 << (2*FB)) / DEG_DIVISOR;
    localparam int NUMW = NORM_BITS + FB + 1;
    localparam int VW = ((MW > FB + 2) ? MW : FB + 2) + 1;
    localparam logic signed [VW-1:0] MAXV = VW'((64'sd1 <<< (CW-1)) - 64'sd1);
    localparam logic signed [VW-1:0] MINV = -MAXV - VW'(1);

    localparam int ST_MAG  = 0;
    localparam int ST_LEAD = 1;
    localparam int ST_NORM = 2;
    localparam int ST_SQ   = 3;
    localparam int ST_SUM  = 4;
    localparam int ST_ROOT = 5;
    localparam int ST_NUM  = ST_ROOT + ROOT_BITS;
    localparam int ST_DIV  = ST_NUM + 1;
    localparam int NC      = ST_DIV + FB + 1;

    typedef struct packed {
        logic                      kind;
        logic                      deg;
        logic [3:0]                sgn;
        logic [PW-1:0]             lead;
        logic [3:0][MW-1:0]        omag;
        logic [3:0][NORM_BITS-1:0] nm;
    } ctx_t;

    ctx_t          ctx_reg [NC];
    logic [NC-1:0] v_reg;
    logic          en;
    logic          m_valid_reg;

    logic [2*NORM_BITS-1:0] sq_reg [4];
    logic [SQ_BITS-1:0]     sum_reg;

    logic [SQ_BITS-1:0]   rad_reg [ROOT_BITS];
    logic [31:0]          srem_reg [ROOT_BITS];
    logic [ROOT_BITS-1:0] sroot_reg [ROOT_BITS];

    logic [NUMW-1:0]      num_reg [4];
    logic [ROOT_BITS-1:0] r_reg;

    logic [NUMW-1:0]      dnum_reg [FB+1][4];
    logic [ROOT_BITS-1:0] drem_reg [FB+1][4];
    logic [FB:0]          dq_reg [FB+1][4];
    logic [ROOT_BITS-1:0] dr_reg [FB+1];

    logic signed [CW-1:0] out_reg [4];
    logic                 fallback_reg;

    assign en = !m_valid_reg || m_ready;
    assign q_ready = en;
    assign m_valid = m_valid_reg;
    assign m_out = out_reg;
    assign m_fallback = fallback_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg <= {v_reg[NC-2:0], q_valid};
            m_valid_reg <= v_reg[NC-1];
        end
    end

    for (genvar s = 0; s < NC; s++) begin : g_ctx
        ctx_t nxt;
        if (s == ST_MAG) begin : g_mag
            always_comb begin
                nxt = '0;
                nxt.kind = q_kind;
                for (int i = 0; i < 4; i++) begin
                    nxt.sgn[i] = q_mix[i][MW-1];
                    nxt.omag[i] = q_mix[i][MW-1] ? MW'(-q_mix[i]) : MW'(q_mix[i]);
                end
            end
        end else if (s == ST_LEAD) begin : g_lead
            logic [MW-1:0]     orm;
            logic [2*SB+1:0]   ssum;
            always_comb begin
                nxt = ctx_reg[s-1];
                orm = '0;
                ssum = '0;
                for (int i = 0; i < 4; i++) begin
                    orm = orm | ctx_reg[s-1].omag[i];
                    ssum = ssum + (2*SB+2)'(ctx_reg[s-1].omag[i][SB-1:0]
                                            * ctx_reg[s-1].omag[i][SB-1:0]);
                end
                nxt.lead = '0;
                for (int b = 0; b < MW; b++) begin
                    if (orm[b]) begin
                        nxt.lead = PW'(b);
                    end
                end
                nxt.deg = ((orm >> SB) == '0) && (64'(ssum) <= THRESH);
            end
        end else if (s == ST_NORM) begin : g_norm
            logic [MW+NORM_TOP-1:0] wide [4];
            always_comb begin
                nxt = ctx_reg[s-1];
                for (int i = 0; i < 4; i++) begin
                    wide[i] = {ctx_reg[s-1].omag[i], {NORM_TOP{1'b0}}} >> ctx_reg[s-1].lead;
                    nxt.nm[i] = wide[i][NORM_BITS-1:0];
                end
            end
        end else begin : g_pass
            assign nxt = ctx_reg[s-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                ctx_reg[s] <= nxt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= ctx_reg[ST_SQ-1].nm[i] * ctx_reg[ST_SQ-1].nm[i];
            end
            sum_reg <= SQ_BITS'(sq_reg[0]) + SQ_BITS'(sq_reg[1])
                     + SQ_BITS'(sq_reg[2]) + SQ_BITS'(sq_reg[3]);
        end
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
        logic [SQ_BITS-1:0]   rad_in;
        logic [31:0]          rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [33:0]          t;
        logic [33:0]          trial;
        if (k == 0) begin : g_first
            assign rad_in = sum_reg;
            assign rem_in = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in = rad_reg[k-1];
            assign rem_in = srem_reg[k-1];
            assign root_in = sroot_reg[k-1];
        end
        assign t = {rem_in, rad_in[SQ_BITS-1-2*k -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k] <= rad_in;
                if (t >= trial) begin
                    srem_reg[k]  <= 32'(t - trial);
                    sroot_reg[k] <= {root_in[ROOT_BITS-2:0], 1'b1};
                end else begin
                    srem_reg[k]  <= t[31:0];
                    sroot_reg[k] <= {root_in[ROOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= sroot_reg[ROOT_BITS-1];
            for (int i = 0; i < 4; i++) begin
                num_reg[i] <= (NUMW'(ctx_reg[ST_NUM-1].nm[i]) << FB)
                            + NUMW'(sroot_reg[ROOT_BITS-1] >> 1);
            end
        end
    end

    for (genvar j = 0; j <= FB; j++) begin : g_div
        logic [NUMW-1:0]      num_in [4];
        logic [ROOT_BITS-1:0] rem_in [4];
        logic [FB:0]          q_in [4];
        logic [ROOT_BITS-1:0] r_in;
        logic [ROOT_BITS:0]   t [4];
        if (j == 0) begin : g_first
            assign r_in = r_reg;
            for (genvar i = 0; i < 4; i++) begin : g_lane
                assign num_in[i] = num_reg[i];
                assign rem_in[i] = ROOT_BITS'(num_reg[i] >> (FB+1));
                assign q_in[i] = '0;
            end
        end else begin : g_next
            assign r_in = dr_reg[j-1];
            assign num_in = dnum_reg[j-1];
            assign rem_in = drem_reg[j-1];
            assign q_in = dq_reg[j-1];
        end
        for (genvar i = 0; i < 4; i++) begin : g_bit
            assign t[i] = {rem_in[i], num_in[i][FB-j]};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dr_reg[j] <= r_in;
                dnum_reg[j] <= num_in;
                for (int i = 0; i < 4; i++) begin
                    if (t[i] >= {1'b0, r_in}) begin
                        drem_reg[j][i] <= ROOT_BITS'(t[i] - {1'b0, r_in});
                        dq_reg[j][i] <= {q_in[i][FB-1:0], 1'b1};
                    end else begin
                        drem_reg[j][i] <= t[i][ROOT_BITS-1:0];
                        dq_reg[j][i] <= {q_in[i][FB-1:0], 1'b0};
                    end
                end
            end
        end
    end

    logic signed [VW-1:0] val [4];
    logic                 deg_out;

    always_comb begin
        deg_out = (ctx_reg[NC-1].kind == KIND_ROTATION) && ctx_reg[NC-1].deg;
        for (int i = 0; i < 4; i++) begin
            if (ctx_reg[NC-1].kind == KIND_LINEAR) begin
                val[i] = ctx_reg[NC-1].sgn[i] ? -VW'(ctx_reg[NC-1].omag[i])
                                              : VW'(ctx_reg[NC-1].omag[i]);
            end else if (deg_out) begin
                val[i] = (i == 3) ? (VW'(1) <<< FB) : '0;
            end else begin
                val[i] = ctx_reg[NC-1].sgn[i] ? -VW'(dq_reg[FB][i]) : VW'(dq_reg[FB][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fallback_reg <= deg_out;
            for (int i = 0; i < 4; i++) begin
                if (val[i] > MAXV) begin
                    out_reg[i] <= CW'(MAXV);
                end else if (val[i] < MINV) begin
                    out_reg[i] <= CW'(MINV);
                end else begin
                    out_reg[i] <= CW'(val[i]);
                end
            end
        end
    end

endmodule

// ----- rtl/transform_vector_blend_core.sv -----
// Top level of the transform vector blend core: weight register, front, queue and back.
//
//   channel | direction | handshake            | word
//   cfg     | in        | cfg_valid/cfg_ready  | blend weight, unsigned Q1.16
//   s_      | in        | s_valid/s_ready      | kind, source and target vectors
//   m_      | out       | m_valid/m_ready      | blended vector, identity flag
//
// One word is accepted per cycle while s_ready is high. The front pipeline and the queue are
// registered; the depth of the back pipeline is set by the one-bit-per-stage square root
// and divider. Reset is synchronous and clears all valid state and the weight.
// A stall on the result channel freezes the back pipeline; the front keeps running until
// the four-word queue is full.
module transform_vector_blend_core import tvb_pkg::*; #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [WEIGHT_BITS:0]              cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic signed [COMPONENT_WIDTH-1:0] s_src_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_src_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_src_z,
    input  logic signed [COMPONENT_WIDTH-1:0] s_src_w,
    input  logic signed [COMPONENT_WIDTH-1:0] s_tgt_x,
    input  logic signed [COMPONENT_WIDTH-1:0] s_tgt_y,
    input  logic signed [COMPONENT_WIDTH-1:0] s_tgt_z,
    input  logic signed [COMPONENT_WIDTH-1:0] s_tgt_w,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [COMPONENT_WIDTH-1:0] m_out_x,
    output logic signed [COMPONENT_WIDTH-1:0] m_out_y,
    output logic signed [COMPONENT_WIDTH-1:0] m_out_z,
    output logic signed [COMPONENT_WIDTH-1:0] m_out_w,
    output logic                              m_identity_fallback
);

    localparam int CW = COMPONENT_WIDTH;

    logic [WEIGHT_BITS:0] weight_reg;
    logic signed [CW-1:0] src [4];
    logic signed [CW-1:0] tgt [4];
    logic signed [CW-1:0] res [4];

    logic                 fq_valid, fq_ready, fq_kind;
    logic signed [CW+2:0] fq_mix [4];
    logic                 qb_valid, qb_ready, qb_kind;
    logic signed [CW+2:0] qb_mix [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= '0;
        end else if (cfg_valid) begin
            weight_reg <= (cfg_data > WEIGHT_ONE) ? WEIGHT_ONE : cfg_data;
        end
    end

    assign src = '{s_src_x, s_src_y, s_src_z, s_src_w};
    assign tgt = '{s_tgt_x, s_tgt_y, s_tgt_z, s_tgt_w};
    assign m_out_x = res[0];
    assign m_out_y = res[1];
    assign m_out_z = res[2];
    assign m_out_w = res[3];

    tvb_front #(.CW(CW)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .weight  (weight_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_src   (src),
        .s_tgt   (tgt),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_kind  (fq_kind),
        .q_mix   (fq_mix)
    );

    tvb_queue #(.CW(CW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_kind   (fq_kind),
        .in_mix    (fq_mix),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_kind  (qb_kind),
        .out_mix   (qb_mix)
    );

    tvb_back #(.CW(CW), .FB(FRACTION_BITS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (qb_valid),
        .q_ready    (qb_ready),
        .q_kind     (qb_kind),
        .q_mix      (qb_mix),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out      (res),
        .m_fallback (m_identity_fallback)
    );

endmodule
